// ===== sv/plc_pkg.sv =====
// ----------------------------------------------------------------------------
// plc_pkg
// Shared types and codes for the positional list: commands, status codes,
// field widths and the control word that is broadcast to every list cell.
// ----------------------------------------------------------------------------
package plc_pkg;

   localparam int CMD_W    = 2;
   localparam int POS_W    = 6;
   localparam int DATA_W   = 32;
   localparam int STATUS_W = 2;
   localparam int INDEX_W  = 6;
   localparam int COUNT_W  = 6;

   localparam logic [CMD_W-1:0] CMD_FIND   = 2'd0;
   localparam logic [CMD_W-1:0] CMD_INSERT = 2'd1;
   localparam logic [CMD_W-1:0] CMD_DELETE = 2'd2;

   localparam logic [STATUS_W-1:0] ST_OK       = 2'd0;
   localparam logic [STATUS_W-1:0] ST_FULL     = 2'd1;
   localparam logic [STATUS_W-1:0] ST_BADPOS   = 2'd2;
   localparam logic [STATUS_W-1:0] ST_NOTFOUND = 2'd3;

   localparam logic signed [INDEX_W-1:0] INDEX_NONE = -6'sd1;

   typedef struct packed {
      logic              ins;
      logic              del;
      logic [DATA_W-1:0] value;
   } cell_ctrl_type;

endpackage

// ===== sv/plc_ifs.sv =====
// ----------------------------------------------------------------------------
// plc_ifs
// Valid/ready channels of the positional list: request and response.
// ----------------------------------------------------------------------------
interface plc_req_if
   import plc_pkg::*;
();
   logic                     valid;
   logic                     ready;
   logic [CMD_W-1:0]         command;
   logic [POS_W-1:0]         position;
   logic signed [DATA_W-1:0] value;

   modport source (output valid, command, position, value, input ready);
   modport sink   (input valid, command, position, value, output ready);
endinterface

interface plc_rsp_if
   import plc_pkg::*;
();
   logic                      valid;
   logic                      ready;
   logic [STATUS_W-1:0]       status;
   logic signed [INDEX_W-1:0] found_index;
   logic [COUNT_W-1:0]        entry_count;

   modport source (output valid, status, found_index, entry_count, input ready);
   modport sink   (input valid, status, found_index, entry_count, output ready);
endinterface

// ===== sv/plc_cell.sv =====
// ----------------------------------------------------------------------------
// plc_cell
// One list slot: holds an entry, shifts it to or takes it from a neighbor
// on insert and delete, and registers whether it matches the search value.
// ----------------------------------------------------------------------------
module plc_cell
   import plc_pkg::*;
#(
   parameter int IDX = 0,
   parameter int CW  = 6
) (
   input  logic              clock,
   input  cell_ctrl_type     ctrl,
   input  logic [CW-1:0]     pos_idx,
   input  logic [CW-1:0]     count,
   input  logic [DATA_W-1:0] left_entry,
   input  logic [DATA_W-1:0] right_entry,
   output logic [DATA_W-1:0] entry,
   output logic              match
);

   localparam logic [CW-1:0] IDX_C = CW'(IDX);

   logic [DATA_W-1:0] entry_ff, entry_in;
   logic              match_ff, match_in;

   always_comb begin
      entry_in = entry_ff;
      if (ctrl.ins && IDX_C == pos_idx) begin
         entry_in = ctrl.value;
      end else if (ctrl.ins && IDX_C > pos_idx) begin
         entry_in = left_entry;
      end else if (ctrl.del && IDX_C >= pos_idx) begin
         entry_in = right_entry;
      end
   end

   assign match_in = (entry_ff == ctrl.value) && (IDX_C < count);

   always_ff @(posedge clock) begin
      entry_ff <= entry_in;
      match_ff <= match_in;
   end

   assign entry = entry_ff;
   assign match = match_ff;

endmodule

// ===== sv/plc_first.sv =====
// ----------------------------------------------------------------------------
// plc_first
// Finds the lowest set bit of the cell match vector and encodes its index.
// ----------------------------------------------------------------------------
module plc_first
   import plc_pkg::*;
#(
   parameter int DEPTH = 32,
   parameter int IW    = 5
) (
   input  logic [DEPTH-1:0] match,
   output logic             found,
   output logic [IW-1:0]    index
);

   logic [DEPTH-1:0] lowest;

   assign lowest = match & (~match + DEPTH'(1));
   assign found  = |match;

   always_comb begin
      index = '0;
      for (int i = 0; i < DEPTH; i++) begin
         if (lowest[i]) begin
            index = index | IW'(i);
         end
      end
   end

endmodule

// ===== sv/positional_list_insert_delete_find.sv =====
// ----------------------------------------------------------------------------
// positional_list_insert_delete_find
// Ordered list of up to DEPTH signed 32-bit values held in a row of cells.
// Find, insert at a 1-based position, delete at a 1-based position.
//
//   port    dir  flow        payload
//   req_if  in   valid/ready command, position, value
//   rsp_if  out  valid/ready status, found_index, entry_count
//
// Find steps through accept, cell update, match encode and response; insert
// and delete skip the match encode. The operation sequencer sets the steps.
// All cells compare or shift together; the first-match encode has a state of its own.
// One item in flight; a held response stalls the request side.
// Reset clears the count and sequencer; entries are not cleared.
// ----------------------------------------------------------------------------
module positional_list_insert_delete_find
   import plc_pkg::*;
#(
   parameter int DEPTH = 32
) (
   input logic       clock,
   input logic       reset,
   plc_req_if.sink   req_if,
   plc_rsp_if.source rsp_if
);

   localparam int CW = $clog2(DEPTH + 1);
   localparam int IW = $clog2(DEPTH);
   localparam int PW = ((CW > POS_W) ? CW : POS_W) + 1;

   typedef enum logic [3:0] {
      S_IDLE = 4'b0001,
      S_WORK = 4'b0010,
      S_FIND = 4'b0100,
      S_RESP = 4'b1000
   } state_type;

   state_type state_ff, state_in;

   logic [CMD_W-1:0]  cmd_ff;
   logic [POS_W-1:0]  pos_ff;
   logic [DATA_W-1:0] val_ff;
   logic [CW-1:0]     count_ff, count_in;

   logic [STATUS_W-1:0]       status_ff, status_in;
   logic signed [INDEX_W-1:0] index_ff, index_in;

   logic                   accept;
   logic [PW-1:0]          pos_ext, cnt_ext;
   logic                   full, ins_bad, del_bad;
   logic [CW-1:0]          pos_idx;
   cell_ctrl_type          ctrl;
   logic [DEPTH-1:0][DATA_W-1:0] entry_q;
   logic [DEPTH-1:0]       match_q;
   logic                   found;
   logic [IW-1:0]          first_idx;
   logic [PW-1:0]          first_ext, count_out;

   assign accept = req_if.valid && req_if.ready;

   assign pos_ext = PW'(pos_ff);
   assign cnt_ext = PW'(count_ff);
   assign full    = count_ff >= CW'(DEPTH);
   assign ins_bad = (pos_ext == '0) || (pos_ext > cnt_ext + PW'(1));
   assign del_bad = (pos_ext == '0) || (pos_ext > cnt_ext);
   assign pos_idx = CW'(pos_ext - PW'(1));

   assign ctrl.ins   = (state_ff == S_WORK) && (cmd_ff == CMD_INSERT) && !full && !ins_bad;
   assign ctrl.del   = (state_ff == S_WORK) && (cmd_ff == CMD_DELETE) && !del_bad;
   assign ctrl.value = val_ff;

   for (genvar g = 0; g < DEPTH; g++) begin : g_cell
      logic [DATA_W-1:0] left_e, right_e;
      if (g == 0) begin : g_first
         assign left_e = val_ff;
      end else begin : g_mid_l
         assign left_e = entry_q[g-1];
      end
      if (g == DEPTH - 1) begin : g_last
         assign right_e = '0;
      end else begin : g_mid_r
         assign right_e = entry_q[g+1];
      end
      plc_cell #(
         .IDX (g),
         .CW  (CW)
      ) u_cell (
         .clock       (clock),
         .ctrl        (ctrl),
         .pos_idx     (pos_idx),
         .count       (count_ff),
         .left_entry  (left_e),
         .right_entry (right_e),
         .entry       (entry_q[g]),
         .match       (match_q[g])
      );
   end

   plc_first #(
      .DEPTH (DEPTH),
      .IW    (IW)
   ) u_first (
      .match (match_q),
      .found (found),
      .index (first_idx)
   );

   assign first_ext = PW'(first_idx);
   assign count_out = PW'(count_ff);

   always_comb begin
      state_in  = state_ff;
      count_in  = count_ff;
      status_in = status_ff;
      index_in  = index_ff;
      case (state_ff)
         S_IDLE: begin
            if (accept) begin
               state_in = S_WORK;
            end
         end
         S_WORK: begin
            index_in = INDEX_NONE;
            state_in = S_RESP;
            case (cmd_ff)
               CMD_FIND: begin
                  state_in = S_FIND;
               end
               CMD_INSERT: begin
                  if (full) begin
                     status_in = ST_FULL;
                  end else if (ins_bad) begin
                     status_in = ST_BADPOS;
                  end else begin
                     status_in = ST_OK;
                     count_in  = count_ff + CW'(1);
                  end
               end
               CMD_DELETE: begin
                  if (del_bad) begin
                     status_in = ST_BADPOS;
                  end else begin
                     status_in = ST_OK;
                     count_in  = count_ff - CW'(1);
                  end
               end
               default: begin
                  status_in = ST_BADPOS;
               end
            endcase
         end
         S_FIND: begin
            state_in = S_RESP;
            if (found) begin
               status_in = ST_OK;
               index_in  = first_ext[INDEX_W-1:0];
            end else begin
               status_in = ST_NOTFOUND;
               index_in  = INDEX_NONE;
            end
         end
         S_RESP: begin
            if (rsp_if.ready) begin
               state_in = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         count_ff <= '0;
      end else begin
         state_ff <= state_in;
         count_ff <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         cmd_ff <= req_if.command;
         pos_ff <= req_if.position;
         val_ff <= req_if.value;
      end
      status_ff <= status_in;
      index_ff  <= index_in;
   end

   assign req_if.ready       = (state_ff == S_IDLE);
   assign rsp_if.valid       = (state_ff == S_RESP);
   assign rsp_if.status      = status_ff;
   assign rsp_if.found_index = index_ff;
   assign rsp_if.entry_count = count_out[COUNT_W-1:0];

`ifndef NO_ASSERTIONS
   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CW'(DEPTH))
      else $error("entry count above depth");

   a_count_only_in_work: assert property (@(posedge clock) disable iff (reset)
      (state_ff != S_WORK) |=> $stable(count_ff))
      else $error("entry count changed outside the update cycle");

   a_insert_grows: assert property (@(posedge clock) disable iff (reset)
      ctrl.ins |=> count_ff == $past(count_ff) + CW'(1))
      else $error("insert did not grow the list");

   a_delete_shrinks: assert property (@(posedge clock) disable iff (reset)
      ctrl.del |=> count_ff == $past(count_ff) - CW'(1))
      else $error("delete did not shrink the list");

   a_index_needs_ok: assert property (@(posedge clock) disable iff (reset)
      (rsp_if.valid && rsp_if.found_index != INDEX_NONE) |-> rsp_if.status == ST_OK)
      else $error("index reported without success");
`endif

endmodule

// ===== dv/tb_top.sv =====
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the positional list. Drives find, insert and
// delete items over the request channel and tracks the list contents on
// the side. Each response is compared in order against the predicted
// status, match index and entry count. The bench runs a directed opening,
// then random fill/mix/drain sequences under several idle and stall
// patterns, including a long response hold-off.
// ----------------------------------------------------------------------------
module tb_top
   import plc_pkg::*;
();

   localparam int LIST_DEPTH      = 32;
   localparam int HOLD_OFF_CYCLES = 300;
   localparam int SETTLE_CYCLES   = 16;
   localparam int PHASE_ITEMS     = 250;

   localparam logic [CMD_W-1:0] CMD_NOP = 2'd3;  // undefined code, answered as bad position

   typedef struct packed {
      logic [STATUS_W-1:0]       status;
      logic signed [INDEX_W-1:0] found_index;
      logic [COUNT_W-1:0]        entry_count;
   } list_result_type;

   class list_tracker;
      logic signed [DATA_W-1:0] entries [LIST_DEPTH];
      int                       count;
      int                       errors;
      list_result_type          pending_results [$];

      function new();
         count  = 0;
         errors = 0;
      endfunction

      task report_mismatch(string what, int got, int want);
         errors++;
         $display("mismatch %0d: %s got %0d expected %0d", errors, what, got, want);
      endtask

      // Applies one accepted item to the tracked list and queues its result.
      function void apply_op(logic [CMD_W-1:0] cmd, logic [POS_W-1:0] pos,
                             logic signed [DATA_W-1:0] val);
         list_result_type r;
         int              p;
         p             = int'(pos);
         r.status      = ST_BADPOS;
         r.found_index = INDEX_NONE;
         case (cmd)
            CMD_FIND: begin
               r.status = ST_NOTFOUND;
               for (int k = count - 1; k >= 0; k--) begin
                  if (entries[k] == val) begin
                     r.status      = ST_OK;
                     r.found_index = k[INDEX_W-1:0];
                  end
               end
            end
            CMD_INSERT: begin
               if (count >= LIST_DEPTH) begin
                  r.status = ST_FULL;
               end else if (p >= 1 && p <= count + 1) begin
                  for (int k = count; k > p - 1; k--) begin
                     entries[k] = entries[k-1];
                  end
                  entries[p-1] = val;
                  count++;
                  r.status = ST_OK;
               end
            end
            CMD_DELETE: begin
               if (p >= 1 && p <= count) begin
                  for (int k = p; k < count; k++) begin
                     entries[k-1] = entries[k];
                  end
                  count--;
                  r.status = ST_OK;
               end
            end
            default: r.status = ST_BADPOS;
         endcase
         r.entry_count = count[COUNT_W-1:0];
         pending_results.push_back(r);
      endfunction

      task check_result(list_result_type got);
         list_result_type want;
         if (pending_results.size() == 0) begin
            report_mismatch("result with none pending, status", int'(got.status), -1);
         end else begin
            want = pending_results.pop_front();
            if (got.status != want.status) begin
               report_mismatch("status", int'(got.status), int'(want.status));
            end
            if (got.found_index != want.found_index) begin
               report_mismatch("found_index", int'(got.found_index), int'(want.found_index));
            end
            if (got.entry_count != want.entry_count) begin
               report_mismatch("entry_count", int'(got.entry_count), int'(want.entry_count));
            end
         end
      endtask
   endclass

   logic clock;
   logic reset;
   int   sender_idle_pct;
   int   receiver_stall_pct;
   bit   hold_request;
   bit   hold_active;

   list_tracker tracker = new();

   plc_req_if req_if ();
   plc_rsp_if rsp_if ();

   positional_list_insert_delete_find #(
      .DEPTH(LIST_DEPTH)
   ) dut (
      .clock (clock),
      .reset (reset),
      .req_if(req_if),
      .rsp_if(rsp_if)
   );

   initial begin
      clock = 1'b0;
      forever #6 clock = ~clock;
   end

   initial begin
      #(12 * 200000);
      $display("Regression FAIL");
      $finish;
   end

   task automatic send_op(input logic [CMD_W-1:0] cmd, input logic [POS_W-1:0] pos,
                          input logic signed [DATA_W-1:0] val);
      while ($urandom_range(0, 99) < sender_idle_pct) begin
         req_if.valid <= 1'b0;
         @(posedge clock);
      end
      req_if.valid    <= 1'b1;
      req_if.command  <= cmd;
      req_if.position <= pos;
      req_if.value    <= val;
      @(posedge clock);
      while (!req_if.ready) @(posedge clock);
      tracker.apply_op(cmd, pos, val);
   endtask

   task automatic wait_for_drain();
      req_if.valid <= 1'b0;
      while (tracker.pending_results.size() != 0) @(posedge clock);
   endtask

   function automatic logic signed [DATA_W-1:0] pick_value();
      int r;
      r = $urandom_range(0, 99);
      if (r < 45) begin
         return $urandom_range(0, 7);
      end else if (r < 55) begin
         case ($urandom_range(0, 3))
            0:       return 32'sh8000_0000;
            1:       return 32'sh7fff_ffff;
            2:       return -32'sd1;
            default: return 32'sd0;
         endcase
      end
      return $urandom();
   endfunction

   task automatic random_op(input int ins_pct, input int del_pct);
      logic [CMD_W-1:0]         cmd;
      logic [POS_W-1:0]         pos;
      logic signed [DATA_W-1:0] val;
      int                       r;
      r = $urandom_range(0, 99);
      if (r < 3) begin
         cmd = CMD_NOP;
      end else if (r < 3 + ins_pct) begin
         cmd = CMD_INSERT;
      end else if (r < 3 + ins_pct + del_pct) begin
         cmd = CMD_DELETE;
      end else begin
         cmd = CMD_FIND;
      end
      pos = POS_W'($urandom_range(0, 63));
      if ($urandom_range(0, 99) < 88) begin
         if (cmd == CMD_INSERT) begin
            pos = POS_W'($urandom_range(1, tracker.count + 1));
         end else if (cmd == CMD_DELETE && tracker.count > 0) begin
            pos = POS_W'($urandom_range(1, tracker.count));
         end
      end
      val = pick_value();
      if (cmd == CMD_FIND && tracker.count > 0 && $urandom_range(0, 99) < 40) begin
         val = tracker.entries[$urandom_range(0, tracker.count - 1)];
      end
      send_op(cmd, pos, val);
   endtask

   // fill toward full, mix, then drain toward empty, repeated
   task automatic run_phase(input int idle_pct, input int stall_pct);
      sender_idle_pct    = idle_pct;
      receiver_stall_pct = stall_pct;
      for (int i = 0; i < PHASE_ITEMS; i++) begin
         if (i % 120 < 60) begin
            random_op(80, 5);
         end else if (i % 120 < 75) begin
            random_op(30, 30);
         end else begin
            random_op(10, 75);
         end
      end
      wait_for_drain();
   endtask

   task automatic run_directed();
      send_op(CMD_FIND,   6'd1,  32'sd0);
      send_op(CMD_DELETE, 6'd1,  32'sd0);
      send_op(CMD_INSERT, 6'd0,  32'sd9);
      send_op(CMD_INSERT, 6'd2,  32'sd9);
      send_op(CMD_INSERT, 6'd1,  32'sh8000_0000);
      send_op(CMD_INSERT, 6'd1,  32'sh7fff_ffff);
      send_op(CMD_INSERT, 6'd3,  -32'sd1);
      send_op(CMD_INSERT, 6'd2,  32'sd0);
      send_op(CMD_INSERT, 6'd63, 32'sd5);
      send_op(CMD_FIND,   6'd0,  32'sh8000_0000);
      send_op(CMD_FIND,   6'd0,  -32'sd1);
      send_op(CMD_FIND,   6'd63, 32'sh7fff_ffff);
      send_op(CMD_FIND,   6'd0,  32'sh8000_0001);
      send_op(CMD_INSERT, 6'd1,  32'sd0);
      send_op(CMD_FIND,   6'd0,  32'sd0);
      send_op(CMD_NOP,    6'd1,  32'sd0);
      send_op(CMD_DELETE, 6'd6,  32'sd0);
      send_op(CMD_DELETE, 6'd0,  32'sd0);
      send_op(CMD_DELETE, 6'd1,  32'sd123);
      send_op(CMD_DELETE, 6'd4,  32'sd0);
      send_op(CMD_DELETE, 6'd2,  32'sd0);
      send_op(CMD_FIND,   6'd0,  32'sd0);
      send_op(CMD_DELETE, 6'd1,  32'sd0);
      send_op(CMD_DELETE, 6'd1,  32'sd0);
      send_op(CMD_DELETE, 6'd1,  32'sd0);
      wait_for_drain();
   endtask

   // long receiver hold-off, counted in cycles
   initial begin
      hold_active = 1'b0;
      wait (hold_request);
      hold_active = 1'b1;
      repeat (HOLD_OFF_CYCLES) @(posedge clock);
      hold_active = 1'b0;
   end

   // response side: check, then drive ready for the next cycle
   initial begin
      list_result_type got;
      rsp_if.ready <= 1'b0;
      forever begin
         @(posedge clock);
         if (!reset && rsp_if.valid && rsp_if.ready) begin
            got.status      = rsp_if.status;
            got.found_index = rsp_if.found_index;
            got.entry_count = rsp_if.entry_count;
            tracker.check_result(got);
         end
         if (hold_active) begin
            rsp_if.ready <= 1'b0;
         end else begin
            rsp_if.ready <= ($urandom_range(0, 99) >= receiver_stall_pct);
         end
      end
   end

   initial begin
      sender_idle_pct    = 0;
      receiver_stall_pct = 0;
      hold_request       = 1'b0;
      reset             <= 1'b1;
      req_if.valid      <= 1'b0;
      req_if.command    <= CMD_FIND;
      req_if.position   <= '0;
      req_if.value      <= '0;
      repeat (12) @(posedge clock);
      reset <= 1'b0;

      run_directed();
      run_phase(0, 0);

      // long response hold-off while items keep coming
      sender_idle_pct    = 0;
      receiver_stall_pct = 0;
      hold_request       = 1'b1;
      for (int i = 0; i < 30; i++) begin
         random_op(50, 20);
      end
      wait_for_drain();

      run_phase(84, 0);
      run_phase(0, 84);
      run_phase(18, 18);

      repeat (SETTLE_CYCLES) @(posedge clock);
      if (tracker.pending_results.size() != 0) begin
         tracker.report_mismatch("results still pending", 0,
                                 tracker.pending_results.size());
      end
      if (tracker.errors == 0) begin
         $display("Regression PASS");
      end else begin
         $display("Regression FAIL");
      end
      $finish;
   end

endmodule
